[rtl/mbg_pkg.sv]
// package for the metronome beat generator
// holds the sequencer state type, register codes, tempo constants and clamp helpers
// no dependencies
package mbg_pkg;

  localparam int CountBits = 16;
  localparam int DivSteps  = 16;
  localparam int CntBits   = $clog2(DivSteps);
  localparam int AddrBits  = 3;

  localparam logic [7:0]  TempoMin       = 8'd20;
  localparam logic [7:0]  TempoMax       = 8'd250;
  localparam logic [7:0]  TempoStep      = 8'd5;
  localparam logic [7:0]  TempoReset     = 8'd90;
  localparam logic [11:0] IntervalReset  = 12'd666;
  localparam logic [2:0]  AccentMax      = 3'd5;
  localparam logic [2:0]  AccentReset    = 3'd4;
  localparam logic [31:0] FirstBeatDelay = 32'd500;
  localparam logic [15:0] MsPerMinute    = 16'd60000;

  typedef enum logic {
    REG_START_TEMPO = 1'b0,
    REG_ACCENT      = 1'b1
  } mbg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CTRL,
    ST_ANCH,
    ST_TICK,
    ST_DIV,
    ST_CMP1,
    ST_ADD,
    ST_CMP2,
    ST_REANCH,
    ST_OUT
  } mbg_state_t;

  function automatic logic [7:0] clamp_tempo(input logic [7:0] t);
    logic [7:0] r;
    r = t;
    if (t < TempoMin) r = TempoMin;
    if (t > TempoMax) r = TempoMax;
    return r;
  endfunction

  function automatic logic [7:0] tempo_down(input logic [7:0] t);
    logic [7:0] r;
    if (t < TempoMin + TempoStep) r = TempoMin;
    else r = t - TempoStep;
    return r;
  endfunction

  function automatic logic [7:0] tempo_up(input logic [7:0] t);
    logic [7:0] r;
    if (t > TempoMax - TempoStep) r = TempoMax;
    else r = t + TempoStep;
    return r;
  endfunction

endpackage

[rtl/metronome_beat_generator_core.sv]
// metronome beat generator top level: sequencer, shared 32-bit adder, apb registers
// depends on mbg_pkg
//
// One word in, one word out. A tick or start word runs from acceptance to the result
// being offered through the control step, an anchor or time-tick step where needed,
// the 16-step restoring division of 60000 by the tempo and, for a tick while running,
// the beat compare, advance and re-anchor steps, all one after another through a single
// shared 32-bit adder/subtractor. The input is not ready while a word is being worked
// on or while its result waits to be taken. Registers: start tempo at byte address 0,
// accent period at byte address 4; write them only while idle.
module metronome_beat_generator_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_action,
  input  logic                         in_button_a,
  input  logic                         in_button_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_click,
  output logic                         out_accent,
  output logic [15:0]                  out_beat_number,
  output logic [7:0]                   out_tempo_bpm,
  output logic                         out_running,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [mbg_pkg::AddrBits-1:0] cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import mbg_pkg::*;

  mbg_state_t state_r, state_nxt;

  logic [7:0]           cfg_tempo_r;
  logic [2:0]           cfg_accent_r;
  logic [31:0]          time_r, time_nxt;
  logic [31:0]          next_r, next_nxt;
  logic [7:0]           tempo_r, tempo_nxt;
  logic [11:0]          interval_r, interval_nxt;
  logic [CountBits-1:0] count_r, count_nxt;
  logic [2:0]           bar_r, bar_nxt;
  logic                 active_r, active_nxt;
  logic                 prev_a_r, prev_a_nxt;
  logic                 prev_b_r, prev_b_nxt;
  logic                 action_r, action_nxt;
  logic                 btn_a_r, btn_a_nxt;
  logic                 btn_b_r, btn_b_nxt;
  logic [7:0]           rem_r, rem_nxt;
  logic [15:0]          quo_r, quo_nxt;
  logic [CntBits-1:0]   cnt_r, cnt_nxt;
  logic                 click_r, click_nxt;
  logic                 accent_r, accent_nxt;
  logic [15:0]          number_r, number_nxt;

  logic [31:0] alu_a, alu_b, alu_sum;
  logic        alu_sub;
  logic        alu_neg;
  logic [8:0]  trial;
  logic        div_last;
  logic        cfg_wr;
  logic [2:0]  period;
  logic [2:0]  bar_base;
  logic [2:0]  bar_inc;

  // shared adder/subtractor
  assign alu_sum  = alu_a + (alu_sub ? ~alu_b : alu_b) + {31'd0, alu_sub};
  assign alu_neg  = alu_sum[31];
  assign trial    = {rem_r, quo_r[15]};
  assign div_last = (cnt_r == CntBits'(DivSteps - 1));

  assign period   = (cfg_accent_r > AccentMax) ? AccentMax : cfg_accent_r;
  assign bar_base = (bar_r >= period) ? 3'd0 : bar_r;
  assign bar_inc  = bar_base + 3'd1;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    case (mbg_reg_t'(cfg_paddr[2]))
      REG_START_TEMPO: cfg_prdata = {24'd0, cfg_tempo_r};
      REG_ACCENT:      cfg_prdata = {29'd0, cfg_accent_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_CTRL;
      ST_CTRL: begin
        if (!action_r)      state_nxt = ST_TICK;
        else if (active_r)  state_nxt = ST_DIV;
        else                state_nxt = ST_ANCH;
      end
      ST_ANCH:   state_nxt = ST_DIV;
      ST_TICK:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_last) state_nxt = (!action_r && active_r) ? ST_CMP1 : ST_OUT;
      end
      ST_CMP1:   state_nxt = alu_neg ? ST_OUT : ST_ADD;
      ST_ADD:    state_nxt = ST_CMP2;
      ST_CMP2:   state_nxt = alu_neg ? ST_OUT : ST_REANCH;
      ST_REANCH: state_nxt = ST_OUT;
      ST_OUT:    if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs and adder operand select
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    alu_a     = time_r;
    alu_b     = next_r;
    alu_sub   = 1'b1;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_ANCH: begin
        alu_b   = FirstBeatDelay;
        alu_sub = 1'b0;
      end
      ST_TICK: begin
        alu_b   = 32'd1;
        alu_sub = 1'b0;
      end
      ST_DIV: begin
        alu_a = {23'd0, trial};
        alu_b = {24'd0, tempo_r};
      end
      ST_ADD: begin
        alu_a   = next_r;
        alu_b   = {20'd0, interval_r};
        alu_sub = 1'b0;
      end
      ST_REANCH: begin
        alu_b   = {20'd0, interval_r};
        alu_sub = 1'b0;
      end
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    time_nxt     = time_r;
    next_nxt     = next_r;
    tempo_nxt    = tempo_r;
    interval_nxt = interval_r;
    count_nxt    = count_r;
    bar_nxt      = bar_r;
    active_nxt   = active_r;
    prev_a_nxt   = prev_a_r;
    prev_b_nxt   = prev_b_r;
    action_nxt   = action_r;
    btn_a_nxt    = btn_a_r;
    btn_b_nxt    = btn_b_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    cnt_nxt      = cnt_r;
    click_nxt    = click_r;
    accent_nxt   = accent_r;
    number_nxt   = number_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          action_nxt = in_action;
          btn_a_nxt  = in_button_a;
          btn_b_nxt  = in_button_b;
          click_nxt  = 1'b0;
          accent_nxt = 1'b0;
          number_nxt = 16'd0;
        end
      end
      ST_CTRL: begin
        rem_nxt = 8'd0;
        quo_nxt = MsPerMinute;
        cnt_nxt = '0;
        if (action_r) begin
          tempo_nxt = clamp_tempo(cfg_tempo_r);
          if (!active_r) begin
            count_nxt  = '0;
            bar_nxt    = 3'd0;
            prev_a_nxt = 1'b0;
            prev_b_nxt = 1'b0;
          end
        end else if (active_r) begin
          if (btn_a_r && btn_b_r) begin
            active_nxt = 1'b0;
          end else begin
            if (btn_a_r && !prev_a_r) tempo_nxt = tempo_down(tempo_r);
            if (btn_b_r && !prev_b_r) tempo_nxt = tempo_up(tempo_r);
            prev_a_nxt = btn_a_r;
            prev_b_nxt = btn_b_r;
          end
        end
      end
      ST_ANCH: begin
        next_nxt   = alu_sum;
        active_nxt = 1'b1;
      end
      ST_TICK: time_nxt = alu_sum;
      ST_DIV: begin
        quo_nxt = {quo_r[14:0], ~alu_neg};
        rem_nxt = alu_neg ? trial[7:0] : alu_sum[7:0];
        cnt_nxt = cnt_r + CntBits'(1);
        if (div_last) interval_nxt = {quo_r[10:0], ~alu_neg};
      end
      ST_CMP1: begin
        if (!alu_neg) begin
          click_nxt  = 1'b1;
          number_nxt = 16'(count_r);
          count_nxt  = count_r + CountBits'(1);
          if (period != 3'd0) begin
            accent_nxt = (bar_base == 3'd0);
            bar_nxt    = (bar_inc >= period) ? 3'd0 : bar_inc;
          end else begin
            bar_nxt = 3'd0;
          end
        end
      end
      ST_ADD:    next_nxt = alu_sum;
      ST_REANCH: next_nxt = alu_sum;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cfg_tempo_r  <= TempoReset;
      cfg_accent_r <= AccentReset;
      time_r       <= 32'd0;
      next_r       <= 32'd0;
      tempo_r      <= TempoReset;
      interval_r   <= IntervalReset;
      count_r      <= '0;
      bar_r        <= 3'd0;
      active_r     <= 1'b0;
      prev_a_r     <= 1'b0;
      prev_b_r     <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      time_r     <= time_nxt;
      next_r     <= next_nxt;
      tempo_r    <= tempo_nxt;
      interval_r <= interval_nxt;
      count_r    <= count_nxt;
      bar_r      <= bar_nxt;
      active_r   <= active_nxt;
      prev_a_r   <= prev_a_nxt;
      prev_b_r   <= prev_b_nxt;
      cnt_r      <= cnt_nxt;
      if (cfg_wr) begin
        case (mbg_reg_t'(cfg_paddr[2]))
          REG_START_TEMPO: cfg_tempo_r  <= cfg_pwdata[7:0];
          REG_ACCENT:      cfg_accent_r <= cfg_pwdata[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    action_r <= action_nxt;
    btn_a_r  <= btn_a_nxt;
    btn_b_r  <= btn_b_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    click_r  <= click_nxt;
    accent_r <= accent_nxt;
    number_r <= number_nxt;
  end

  assign out_click       = click_r;
  assign out_accent      = accent_r;
  assign out_beat_number = number_r;
  assign out_tempo_bpm   = tempo_r;
  assign out_running     = active_r;

`ifndef SYNTHESIS
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_tempo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (tempo_r >= TempoMin) && (tempo_r <= TempoMax))
    else $error("tempo out of range");

  a_interval_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (interval_r >= 12'd240) && (interval_r <= 12'd3000))
    else $error("beat interval out of range after division");

  a_click_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_click) |-> out_running)
    else $error("click while stopped");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CTRL))
    else $error("accepted word did not start the sequencer");
`endif

endmodule
